/* src/lsfb_pkg.sv */
// ---------------------------------------------------------------------------
// lsfb_pkg
// Shared widths, sideband type and elaboration-time constant tables for the
// log-sigmoid forward/backward pipeline.
// ---------------------------------------------------------------------------
package lsfb_pkg;

  localparam int DATA_W     = 16;          // Q4.12 word
  localparam int FRAC_W     = 12;
  localparam int UF         = 48;          // fraction bits of e^-|x| and sigmoid
  localparam int UW         = UF + 1;
  localparam int SPLIT      = UF / 2;      // partial-product split point
  localparam int ZF         = UF + 1;      // fraction bits in the log unit
  localparam int ZW         = ZF + 1;
  localparam int DIV_STAGES = UF / 2;      // two quotient bits per stage
  localparam int LN_STEPS   = DIV_STAGES;  // keeps both units the same depth
  localparam int TAB_N      = 256;

  typedef logic [UW-1:0] u_word_t;
  typedef logic [ZW-1:0] z_word_t;
  typedef u_word_t exp_tab_t [TAB_N];
  typedef z_word_t ln_tab_t [LN_STEPS];

  typedef struct packed {
    logic                     op;
    logic                     neg;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] g;
  } side_t;

  // e^-(i*step) in UF fraction bits
  function automatic exp_tab_t build_exp_tab(input real step);
    exp_tab_t tab;
    real      v;
    for (int i = 0; i < TAB_N; i++) begin
      v      = $exp(-step * i) * $pow(2.0, UF);
      tab[i] = UW'(longint'(v));
    end
    return tab;
  endfunction

  function automatic z_word_t ln_fix(input real v);
    return ZW'(longint'($ln(v) * $pow(2.0, ZF)));
  endfunction

  // ln(1 + 2^-(i+1))
  function automatic ln_tab_t build_ln_tab();
    ln_tab_t tab;
    for (int i = 0; i < LN_STEPS; i++) begin
      tab[i] = ln_fix(1.0 + $pow(2.0, -(i + 1)));
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_HI = build_exp_tab($pow(2.0, 8 - FRAC_W));
  localparam exp_tab_t EXP_LO = build_exp_tab($pow(2.0, -FRAC_W));
  localparam ln_tab_t  LN_TAB = build_ln_tab();
  localparam z_word_t  LN2_Z  = ln_fix(2.0);
  localparam z_word_t  ONE_Z  = ZW'(1) << ZF;
  localparam u_word_t  ONE_U  = UW'(1) << UF;

endpackage

/* src/lsfb_exp.sv */
// ---------------------------------------------------------------------------
// lsfb_exp
// Input capture and e^-|x|: two 256-entry tables and one split product.
// ---------------------------------------------------------------------------
module lsfb_exp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  lsfb_pkg::side_t in_side,
  output logic            out_vld,
  output lsfb_pkg::side_t out_side,
  output logic [lsfb_pkg::UW-1:0] out_u
);
  import lsfb_pkg::*;

  localparam int HI_W  = UW - SPLIT;
  localparam int SUM_W = 2 * UW;

  logic        vld0_r, vld1_r, vld2_r, vld3_r, vld4_r;
  side_t       side0_r, side1_r, side2_r, side3_r, side4_r;

  logic [DATA_W-1:0] ax;
  u_word_t           ehi_nxt, elo_nxt, ehi_r, elo_r;

  logic [2*HI_W-1:0]  hh_nxt, hh2_r, hh3_r;
  logic [UW-1:0]      hl_nxt, lh_nxt, hl2_r, lh2_r;
  logic [2*SPLIT-1:0] ll_nxt, ll2_r, ll3_r;
  logic [UW:0]        mid_nxt, mid3_r;
  logic [SUM_W-1:0]   sum;
  u_word_t            u_nxt, u4_r;

  // |x| as unsigned; -32768 maps to 32768
  always_comb begin
    ax      = side0_r.neg ? DATA_W'(-side0_r.x) : DATA_W'(side0_r.x);
    ehi_nxt = EXP_HI[ax[DATA_W-1:8]];
    elo_nxt = EXP_LO[ax[7:0]];
  end

  always_comb begin
    hh_nxt = (2*HI_W)'(ehi_r[UW-1:SPLIT]) * (2*HI_W)'(elo_r[UW-1:SPLIT]);
    hl_nxt = UW'(ehi_r[UW-1:SPLIT]) * UW'(elo_r[SPLIT-1:0]);
    lh_nxt = UW'(ehi_r[SPLIT-1:0]) * UW'(elo_r[UW-1:SPLIT]);
    ll_nxt = (2*SPLIT)'(ehi_r[SPLIT-1:0]) * (2*SPLIT)'(elo_r[SPLIT-1:0]);
  end

  assign mid_nxt = (UW+1)'(hl2_r) + (UW+1)'(lh2_r);

  always_comb begin
    sum   = (SUM_W'(hh3_r) << (2 * SPLIT)) + (SUM_W'(mid3_r) << SPLIT)
          + SUM_W'(ll3_r) + (SUM_W'(1) << (UF - 1));
    u_nxt = sum[UF+UW-1:UF];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    side0_r <= in_side;
    side1_r <= side0_r;
    side2_r <= side1_r;
    side3_r <= side2_r;
    side4_r <= side3_r;
    ehi_r   <= ehi_nxt;
    elo_r   <= elo_nxt;
    hh2_r   <= hh_nxt;
    hl2_r   <= hl_nxt;
    lh2_r   <= lh_nxt;
    ll2_r   <= ll_nxt;
    hh3_r   <= hh2_r;
    mid3_r  <= mid_nxt;
    ll3_r   <= ll2_r;
    u4_r    <= u_nxt;
  end

  assign out_vld  = vld4_r;
  assign out_side = side4_r;
  assign out_u    = u4_r;

endmodule

/* src/lsfb_ln.sv */
// ---------------------------------------------------------------------------
// lsfb_ln
// ln(1+u) by multiplicative normalization: z = (1+u)/2 is driven toward 1
// with factors (1 + 2^-k), one factor per stage, summing ln(1 + 2^-k).
// ---------------------------------------------------------------------------
module lsfb_ln (
  input  logic                    clk,
  input  logic [lsfb_pkg::UW-1:0] in_u,
  output logic [lsfb_pkg::ZW-1:0] out_z,
  output logic [lsfb_pkg::ZW-1:0] out_acc
);
  import lsfb_pkg::*;

  z_word_t z_r   [LN_STEPS];
  z_word_t acc_r [LN_STEPS];
  z_word_t z0;

  assign z0 = (ONE_Z >> 1) + ZW'(in_u);

  for (genvar i = 0; i < LN_STEPS; i++) begin : g_step
    z_word_t z_in, acc_in, t, z_nxt, acc_nxt;
    logic    take;

    if (i == 0) begin : g_first
      assign z_in   = z0;
      assign acc_in = '0;
    end else begin : g_next
      assign z_in   = z_r[i-1];
      assign acc_in = acc_r[i-1];
    end

    assign t       = z_in + (z_in >> (i + 1));
    assign take    = (t <= ONE_Z);
    assign z_nxt   = take ? t : z_in;
    assign acc_nxt = take ? acc_in + LN_TAB[i] : acc_in;

    always_ff @(posedge clk) begin
      z_r[i]   <= z_nxt;
      acc_r[i] <= acc_nxt;
    end
  end

  assign out_z   = z_r[LN_STEPS-1];
  assign out_acc = acc_r[LN_STEPS-1];

endmodule

/* src/lsfb_div.sv */
// ---------------------------------------------------------------------------
// lsfb_div
// Pipelined restoring divider: s = u / (1 + u), two quotient bits per stage.
// Carries the valid bit and the sideband word for the whole datapath.
// ---------------------------------------------------------------------------
module lsfb_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  lsfb_pkg::side_t         in_side,
  input  logic [lsfb_pkg::UW-1:0] in_u,
  output logic                    out_vld,
  output lsfb_pkg::side_t         out_side,
  output logic [lsfb_pkg::UF-1:0] out_s
);
  import lsfb_pkg::*;

  localparam int RW = UW + 1;

  logic [RW-1:0] r_r   [DIV_STAGES];
  logic [RW-1:0] den_r [DIV_STAGES];
  logic [UF-1:0] q_r   [DIV_STAGES];
  logic          vld_r [DIV_STAGES];
  side_t         side_r[DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [RW-1:0] r_in, den_in, r1, ra, r2, rb;
    logic [UF-1:0] q_in, q_nxt;
    logic          vld_in, b1, b2;
    side_t         side_in;

    if (j == 0) begin : g_first
      assign r_in    = RW'(in_u);
      assign den_in  = RW'(ONE_U) + RW'(in_u);
      assign q_in    = '0;
      assign vld_in  = in_vld;
      assign side_in = in_side;
    end else begin : g_next
      assign r_in    = r_r[j-1];
      assign den_in  = den_r[j-1];
      assign q_in    = q_r[j-1];
      assign vld_in  = vld_r[j-1];
      assign side_in = side_r[j-1];
    end

    // remainder stays below den <= 2^(UF+1), so the top bit shifts out empty
    always_comb begin
      r1    = {r_in[RW-2:0], 1'b0};
      b1    = (r1 >= den_in);
      ra    = b1 ? r1 - den_in : r1;
      r2    = {ra[RW-2:0], 1'b0};
      b2    = (r2 >= den_in);
      rb    = b2 ? r2 - den_in : r2;
      q_nxt = {q_in[UF-3:0], b1, b2};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      r_r[j]    <= rb;
      den_r[j]  <= den_in;
      q_r[j]    <= q_nxt;
      side_r[j] <= side_in;
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];
  assign out_s    = q_r[DIV_STAGES-1];

endmodule

/* src/lsfb_out.sv */
// ---------------------------------------------------------------------------
// lsfb_out
// Result back end: log rounding, gradient product, sign, select, saturate.
// ---------------------------------------------------------------------------
module lsfb_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  lsfb_pkg::side_t             in_side,
  input  logic [lsfb_pkg::UF-1:0]     in_s,
  input  logic [lsfb_pkg::ZW-1:0]     in_z,
  input  logic [lsfb_pkg::ZW-1:0]     in_acc,
  output logic                        out_vld,
  output logic signed [lsfb_pkg::DATA_W-1:0] out_result
);
  import lsfb_pkg::*;

  localparam int LS_W = ZW + 2;
  localparam int PH_W = DATA_W + UW - SPLIT;
  localparam int PL_W = DATA_W + SPLIT;
  localparam int PR_W = PH_W + SPLIT + 1;
  localparam int RS_W = DATA_W + 2;

  // stage 1
  logic [LS_W-1:0]   lsum;
  logic [FRAC_W-1:0] d_nxt, d1_r;
  u_word_t           q_nxt, q1_r;
  logic              vld1_r;
  side_t             side1_r;

  // stage 2
  logic [DATA_W-1:0]      g_abs;
  logic [PH_W-1:0]        ph_nxt, ph2_r;
  logic [PL_W-1:0]        pl_nxt, pl2_r;
  logic signed [RS_W-1:0] xs, ds, fwd_nxt, fwd2_r;
  logic                   vld2_r, op2_r, gneg2_r;

  // stage 3
  logic [PR_W-1:0]          prod;
  logic signed [RS_W-1:0]   mag, bwd, val;
  logic signed [DATA_W-1:0] res_nxt, res_r;
  logic                     vld3_r;

  // ln(1+u) = ln2 - sum ln(1+2^-k) - (1 - z); then round to FRAC_W bits
  always_comb begin
    lsum  = LS_W'(LN2_Z) + LS_W'(in_z) - LS_W'(ONE_Z) - LS_W'(in_acc)
          + (LS_W'(1) << (ZF - FRAC_W - 1));
    d_nxt = lsum[ZF-1:ZF-FRAC_W];
    q_nxt = in_side.neg ? ONE_U - UW'(in_s) : UW'(in_s);
  end

  always_comb begin
    g_abs   = side1_r.g[DATA_W-1] ? DATA_W'(-side1_r.g) : DATA_W'(side1_r.g);
    ph_nxt  = PH_W'(g_abs) * PH_W'(q1_r[UW-1:SPLIT]);
    pl_nxt  = PL_W'(g_abs) * PL_W'(q1_r[SPLIT-1:0]);
    xs      = RS_W'(side1_r.x);
    ds      = RS_W'(d1_r);
    fwd_nxt = side1_r.neg ? xs - ds : -ds;
  end

  always_comb begin
    prod = (PR_W'(ph2_r) << SPLIT) + PR_W'(pl2_r) + (PR_W'(1) << (UF - 1));
    mag  = RS_W'(prod[UF+DATA_W:UF]);
    bwd  = gneg2_r ? -mag : mag;
    val  = op2_r ? bwd : fwd2_r;
    if (val[RS_W-1:DATA_W-1] == '0 || val[RS_W-1:DATA_W-1] == '1) begin
      res_nxt = val[DATA_W-1:0];
    end else if (val[RS_W-1]) begin
      res_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_r    <= d_nxt;
    q1_r    <= q_nxt;
    side1_r <= in_side;
    ph2_r   <= ph_nxt;
    pl2_r   <= pl_nxt;
    fwd2_r  <= fwd_nxt;
    op2_r   <= side1_r.op;
    gneg2_r <= side1_r.g[DATA_W-1];
    res_r   <= res_nxt;
  end

  assign out_vld    = vld3_r;
  assign out_result = res_r;

endmodule

/* src/log_sigmoid_forward_backward.sv */
// ---------------------------------------------------------------------------
// log_sigmoid_forward_backward
// Log-sigmoid activation and its gradient on signed Q4.12 words.
// ---------------------------------------------------------------------------
// channel  ports                                        handshake
// input    in_op, in_x_value, in_upstream_grad          start & !busy
// result   out_result_value                             out_valid, one cycle
//
// One word is accepted every cycle; busy never rises.
// Between the edge that took its word and its strobe, each result passes 5 stages
// of table lookup and split product for e^-|x|, 24 stages of the log
// normalization and divider run side by side, 3 stages of rounding/select.
// Reset clears only the valid bits; no clearing pass is needed.
// The result side takes every strobe, so the pipeline never stalls.
// ---------------------------------------------------------------------------
module log_sigmoid_forward_backward (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [lsfb_pkg::DATA_W-1:0]  in_x_value,
  input  logic signed [lsfb_pkg::DATA_W-1:0]  in_upstream_grad,
  output logic                                out_valid,
  output logic signed [lsfb_pkg::DATA_W-1:0]  out_result_value
);
  import lsfb_pkg::*;

  side_t         in_side, exp_side, div_side;
  logic          exp_vld, div_vld;
  u_word_t       u;
  logic [UF-1:0] s;
  z_word_t       z, acc;

  assign busy = 1'b0;

  always_comb begin
    in_side.op  = in_op;
    in_side.neg = in_x_value[DATA_W-1];
    in_side.x   = in_x_value;
    in_side.g   = in_upstream_grad;
  end

  lsfb_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_side  (in_side),
    .out_vld  (exp_vld),
    .out_side (exp_side),
    .out_u    (u)
  );

  lsfb_ln u_ln (
    .clk     (clk),
    .in_u    (u),
    .out_z   (z),
    .out_acc (acc)
  );

  lsfb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (exp_vld),
    .in_side  (exp_side),
    .in_u     (u),
    .out_vld  (div_vld),
    .out_side (div_side),
    .out_s    (s)
  );

  lsfb_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (div_vld),
    .in_side    (div_side),
    .in_s       (s),
    .in_z       (z),
    .in_acc     (acc),
    .out_vld    (out_valid),
    .out_result (out_result_value)
  );

endmodule
